### rtl/sppd_pkg.sv
// ----------------------------------------------------------------------------
// sppd_pkg
// Shared types and fixed constants of the stereo ping-pong delay: register
// indexes, gain limits, fixed-point shift amounts and lane control.
// ----------------------------------------------------------------------------
package sppd_pkg;

	// configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LENGTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_COEFF  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RETURN_GAIN   = 3'd3;

	// register widths and limits
	localparam int DELAY_BITS = 16;
	localparam int FB_BITS    = 15;
	localparam int GAIN_BITS  = 16;

	localparam logic [FB_BITS-1:0]   FB_LIMIT       = 15'd31130;
	localparam logic [GAIN_BITS-1:0] UNITY_Q15      = 16'd32768;
	localparam logic [DELAY_BITS-1:0] DELAY_RESET   = 16'd1;

	// fixed point
	localparam int Q15_SHIFT  = 15;
	localparam int ROUND_HALF = 16384;
	localparam int EXTRA_BITS = 8;

	// per-lane stage strobes
	typedef struct packed {
		logic mul_en;
		logic filt_en;
		logic gain_en;
	} sppd_lane_ctrl_t;

	// clamped gains, all Q1.15 unsigned
	typedef struct packed {
		logic [GAIN_BITS-1:0] coeff;
		logic [GAIN_BITS-1:0] feedback;
		logic [GAIN_BITS-1:0] ret;
	} sppd_gain_t;

endpackage

### rtl/sppd_if.sv
// ----------------------------------------------------------------------------
// sppd_if
// Valid/ready channels of the stereo ping-pong delay: the input frame and
// the mixed result.
// ----------------------------------------------------------------------------
interface sppd_frame_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] send_left;
	logic signed [SAMPLE_BITS-1:0] send_right;
	logic signed [SAMPLE_BITS-1:0] mix_in_left;
	logic signed [SAMPLE_BITS-1:0] mix_in_right;
	logic                          block_end_in;

	modport source (
		output valid, send_left, send_right, mix_in_left, mix_in_right, block_end_in,
		input  ready
	);
	modport sink (
		input  valid, send_left, send_right, mix_in_left, mix_in_right, block_end_in,
		output ready
	);
endinterface

interface sppd_mix_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mix_out_left;
	logic signed [SAMPLE_BITS-1:0] mix_out_right;
	logic                          block_end_out;

	modport source (
		output valid, mix_out_left, mix_out_right, block_end_out,
		input  ready
	);
	modport sink (
		input  valid, mix_out_left, mix_out_right, block_end_out,
		output ready
	);
endinterface

### rtl/stereo_pingpong_delay_filtered.sv
// ----------------------------------------------------------------------------
// stereo_pingpong_delay_filtered
// Stereo ping-pong delay with a one-pole lowpass in the cross feedback path.
// ----------------------------------------------------------------------------
// A frame passes the delay RAM read, the filter multiply, the filter update,
// the gain multiplies and the merge that writes the RAM and loads the output
// register; the merge waits while the output still holds an unaccepted result,
// and the next frame's read must follow that write. Both channels run in two
// parallel lanes. A finished result waits in the output register while the
// next frame is accepted. The delay memory reads as zero until the write
// pointer has passed an entry once, so no clearing pass is needed after reset.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// no frame is in flight; the block itself does not enforce this.
module stereo_pingpong_delay_filtered #(
	parameter int DELAY_DEPTH = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	sppd_frame_if.sink                             frame,
	sppd_mix_if.source                             result,
	input  logic                                   cfg_we,
	input  logic [sppd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [sppd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import sppd_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int LW = (AW > DELAY_BITS) ? AW : DELAY_BITS;
	localparam int SB = SAMPLE_BITS;

	localparam logic [LW-1:0] D_MAX = LW'(DELAY_DEPTH - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_FILT  = 3'd2;
	localparam logic [2:0] ST_GAIN  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;

	// configuration registers
	logic [DELAY_BITS-1:0] delay_length_q;
	logic [FB_BITS-1:0]    feedback_gain_q;
	logic [GAIN_BITS-1:0]  filter_coeff_q;
	logic [GAIN_BITS-1:0]  return_gain_q;

	logic [2:0]            state_q;
	logic [2:0]            state_d;
	logic [AW-1:0]         wp_q;
	logic                  wrapped_q;
	logic                  rd_ok_s1;

	logic [LW-1:0]         d_raw;
	logic [LW-1:0]         d_eff;
	logic [LW:0]           wp_x;
	logic [LW:0]           rd_x;
	logic [AW-1:0]         rd_addr;
	logic                  rd_ok;

	logic                  in_acc;
	logic                  out_free;
	logic                  commit;
	logic [2*SB-1:0]       ram_rd;
	logic [2*SB-1:0]       ram_wr;

	logic signed [SB-1:0]  send_left_q;
	logic signed [SB-1:0]  send_right_q;
	logic signed [SB-1:0]  mix_left_q;
	logic signed [SB-1:0]  mix_right_q;
	logic                  block_end_q;

	logic signed [SB-1:0]  echo_left;
	logic signed [SB-1:0]  echo_right;
	logic signed [SB+16:0] fb_left;
	logic signed [SB+16:0] fb_right;
	logic signed [SB+16:0] ret_left;
	logic signed [SB+16:0] ret_right;
	logic signed [SB-1:0]  wr_left;
	logic signed [SB-1:0]  wr_right;
	logic signed [SB-1:0]  sum_left;
	logic signed [SB-1:0]  sum_right;

	logic                  out_valid_q;
	logic signed [SB-1:0]  out_left_q;
	logic signed [SB-1:0]  out_right_q;
	logic                  out_end_q;

	sppd_lane_ctrl_t       lane_ctrl;
	sppd_gain_t            gain;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q  <= DELAY_RESET;
			feedback_gain_q <= '0;
			filter_coeff_q  <= UNITY_Q15;
			return_gain_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH:  delay_length_q  <= cfg_data;
				REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data[FB_BITS-1:0];
				REG_FILTER_COEFF:  filter_coeff_q  <= cfg_data;
				REG_RETURN_GAIN:   return_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped gains
	always_comb begin
		gain.coeff    = (filter_coeff_q > UNITY_Q15) ? UNITY_Q15 : filter_coeff_q;
		gain.ret      = (return_gain_q > UNITY_Q15) ? UNITY_Q15 : return_gain_q;
		gain.feedback = {1'b0, (feedback_gain_q > FB_LIMIT) ? FB_LIMIT : feedback_gain_q};
	end

	// read address: clamp the delay, step back from the write pointer with wrap
	assign d_raw = LW'(delay_length_q);
	always_comb begin
		priority if (d_raw == '0) begin
			d_eff = LW'(1);
		end else if (d_raw > D_MAX) begin
			d_eff = D_MAX;
		end else begin
			d_eff = d_raw;
		end
	end

	assign wp_x = (LW+1)'(wp_q);
	always_comb begin
		if (wp_x >= (LW+1)'(d_eff)) begin
			rd_x = wp_x - (LW+1)'(d_eff);
		end else begin
			rd_x = wp_x + (LW+1)'(DELAY_DEPTH) - (LW+1)'(d_eff);
		end
	end
	assign rd_addr = rd_x[AW-1:0];

	// entries are written in address order, so anything behind the pointer is live
	assign rd_ok = wrapped_q || (rd_addr < wp_q);

	// sequencer
	assign in_acc      = frame.valid && frame.ready;
	assign frame.ready = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || result.ready;
	assign commit      = (state_q == ST_WRITE) && out_free;

	always_comb begin
		unique case (state_q)
			ST_IDLE:  state_d = in_acc ? ST_MUL : ST_IDLE;
			ST_MUL:   state_d = ST_FILT;
			ST_FILT:  state_d = ST_GAIN;
			ST_GAIN:  state_d = ST_WRITE;
			ST_WRITE: state_d = out_free ? ST_IDLE : ST_WRITE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign lane_ctrl.mul_en  = (state_q == ST_MUL);
	assign lane_ctrl.filt_en = (state_q == ST_FILT);
	assign lane_ctrl.gain_en = (state_q == ST_GAIN);

	// write pointer and first-pass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rd_ok_s1  <= 1'b0;
		end else begin
			if (in_acc) begin
				rd_ok_s1 <= rd_ok;
			end
			if (commit) begin
				if (wp_q == AW'(DELAY_DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
		end
	end

	// frame payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			send_left_q  <= frame.send_left;
			send_right_q <= frame.send_right;
			mix_left_q   <= frame.mix_in_left;
			mix_right_q  <= frame.mix_in_right;
			block_end_q  <= frame.block_end_in;
		end
	end

	// delay memory, left in the low half
	sppd_ram #(
		.WIDTH (2 * SB),
		.DEPTH (DELAY_DEPTH)
	) u_echo_ram (
		.clk     (clk),
		.wr_en   (commit),
		.wr_addr (wp_q),
		.wr_data (ram_wr),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	assign ram_wr     = {wr_right, wr_left};
	assign echo_left  = rd_ok_s1 ? $signed(ram_rd[SB-1:0]) : '0;
	assign echo_right = rd_ok_s1 ? $signed(ram_rd[2*SB-1:SB]) : '0;

	// lanes
	sppd_lane #(
		.SAMPLE_BITS (SB)
	) u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lane_ctrl),
		.gain     (gain),
		.echo     (echo_left),
		.fb_prod  (fb_left),
		.ret_prod (ret_left)
	);

	sppd_lane #(
		.SAMPLE_BITS (SB)
	) u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lane_ctrl),
		.gain     (gain),
		.echo     (echo_right),
		.fb_prod  (fb_right),
		.ret_prod (ret_right)
	);

	sppd_merge #(
		.SAMPLE_BITS (SB)
	) u_merge (
		.send_left  (send_left_q),
		.send_right (send_right_q),
		.mix_left   (mix_left_q),
		.mix_right  (mix_right_q),
		.fb_left    (fb_left),
		.fb_right   (fb_right),
		.ret_left   (ret_left),
		.ret_right  (ret_right),
		.wr_left    (wr_left),
		.wr_right   (wr_right),
		.out_left   (sum_left),
		.out_right  (sum_right)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_left_q  <= sum_left;
			out_right_q <= sum_right;
			out_end_q   <= block_end_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.mix_out_left  = out_left_q;
	assign result.mix_out_right = out_right_q;
	assign result.block_end_out = out_end_q;

endmodule

### rtl/sppd_ram.sv
// ----------------------------------------------------------------------------
// sppd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sppd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/sppd_lane.sv
// ----------------------------------------------------------------------------
// sppd_lane
// One channel of the delay: one-pole lowpass on the delayed sample, then
// the feedback and return gain products of the filtered wet sample.
// ----------------------------------------------------------------------------
module sppd_lane #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sppd_pkg::sppd_lane_ctrl_t     ctrl,
	input  sppd_pkg::sppd_gain_t          gain,
	input  logic signed [SAMPLE_BITS-1:0] echo,
	output logic signed [SAMPLE_BITS+16:0] fb_prod,
	output logic signed [SAMPLE_BITS+16:0] ret_prod
);
	import sppd_pkg::*;

	localparam int SSW = SAMPLE_BITS + EXTRA_BITS; // filter state
	localparam int DW  = SSW + 1;                  // difference
	localparam int PW  = DW + GAIN_BITS + 1;       // filter product
	localparam int AW  = PW + 1;                   // filter update sum
	localparam int GW  = SAMPLE_BITS + GAIN_BITS + 1;

	logic signed [SSW-1:0]         smooth_q;
	logic signed [SSW-1:0]         echo_sh;
	logic signed [DW-1:0]          diff;
	logic signed [GAIN_BITS:0]     coeff_s;
	logic signed [PW-1:0]          filt_prod_s1;
	logic signed [AW-1:0]          s_sum;
	logic signed [SSW-1:0]         s_next;
	logic signed [SAMPLE_BITS-1:0] wet_s2;
	logic signed [GW-1:0]          fb_prod_s3;
	logic signed [GW-1:0]          ret_prod_s3;

	// stage 1: c * ((x << 8) - s)
	assign echo_sh = $signed({echo, {EXTRA_BITS{1'b0}}});
	assign diff    = DW'(echo_sh) - DW'(smooth_q);
	assign coeff_s = $signed({1'b0, gain.coeff});

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			filt_prod_s1 <= diff * coeff_s;
		end
	end

	// stage 2: s += round(prod / 2^15), folded into one add before the shift
	assign s_sum  = AW'(filt_prod_s1) + (AW'(smooth_q) <<< Q15_SHIFT) + AW'(ROUND_HALF);
	assign s_next = s_sum[Q15_SHIFT +: SSW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (ctrl.filt_en) begin
			smooth_q <= s_next;
		end
	end

	// wet sample is the state floored back to sample precision
	always_ff @(posedge clk) begin
		if (ctrl.filt_en) begin
			wet_s2 <= s_next[SSW-1:EXTRA_BITS];
		end
	end

	// stage 3: gain products, rounding is done in the merge
	always_ff @(posedge clk) begin
		if (ctrl.gain_en) begin
			fb_prod_s3  <= wet_s2 * $signed({1'b0, gain.feedback});
			ret_prod_s3 <= wet_s2 * $signed({1'b0, gain.ret});
		end
	end

	assign fb_prod  = fb_prod_s3;
	assign ret_prod = ret_prod_s3;

endmodule

### rtl/sppd_merge.sv
// ----------------------------------------------------------------------------
// sppd_merge
// Combines the two lanes: cross-feeds each lane's feedback product into the
// opposite channel's send, adds return products to the mix, rounds and
// saturates every sum.
// ----------------------------------------------------------------------------
module sppd_merge #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic signed [SAMPLE_BITS-1:0]  send_left,
	input  logic signed [SAMPLE_BITS-1:0]  send_right,
	input  logic signed [SAMPLE_BITS-1:0]  mix_left,
	input  logic signed [SAMPLE_BITS-1:0]  mix_right,
	input  logic signed [SAMPLE_BITS+16:0] fb_left,
	input  logic signed [SAMPLE_BITS+16:0] fb_right,
	input  logic signed [SAMPLE_BITS+16:0] ret_left,
	input  logic signed [SAMPLE_BITS+16:0] ret_right,
	output logic signed [SAMPLE_BITS-1:0]  wr_left,
	output logic signed [SAMPLE_BITS-1:0]  wr_right,
	output logic signed [SAMPLE_BITS-1:0]  out_left,
	output logic signed [SAMPLE_BITS-1:0]  out_right
);
	import sppd_pkg::*;

	localparam int PW = SAMPLE_BITS + 17;
	localparam int SW = PW + 1;
	localparam int QW = SW - Q15_SHIFT;

	localparam logic signed [QW-1:0] QMAX =
		$signed({{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [QW-1:0] QMIN =
		$signed({{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

	// base + round(prod / 2^15), saturated to the sample range
	function automatic logic signed [SAMPLE_BITS-1:0] mix_sat(
		input logic signed [SAMPLE_BITS-1:0] base,
		input logic signed [PW-1:0]          prod
	);
		logic signed [SW-1:0] sum;
		logic signed [QW-1:0] q;
		sum = SW'(prod) + (SW'(base) <<< Q15_SHIFT) + SW'(ROUND_HALF);
		q   = sum[SW-1:Q15_SHIFT];
		if (q > QMAX) begin
			mix_sat = QMAX[SAMPLE_BITS-1:0];
		end else if (q < QMIN) begin
			mix_sat = QMIN[SAMPLE_BITS-1:0];
		end else begin
			mix_sat = q[SAMPLE_BITS-1:0];
		end
	endfunction

	// ping-pong: left memory takes the right wet and vice versa
	assign wr_left   = mix_sat(send_left, fb_right);
	assign wr_right  = mix_sat(send_right, fb_left);
	assign out_left  = mix_sat(mix_left, ret_left);
	assign out_right = mix_sat(mix_right, ret_right);

endmodule

### rtl/sppd_checker.sv
// ----------------------------------------------------------------------------
// sppd_checker
// Port-level checks of the stereo ping-pong delay, bound to the top level.
// ----------------------------------------------------------------------------
module sppd_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_left,
	input logic [SAMPLE_BITS-1:0] out_right,
	input logic                   out_end
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// frames accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) && $stable(out_end))
		else $error("result payload changed while stalled");

	// one frame in work at a time
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request accepted on the cycle after another");

	// every result belongs to an accepted frame
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 2'd0)
		else $error("result delivered with no frame outstanding");

endmodule

bind stereo_pingpong_delay_filtered sppd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_sppd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame.valid),
	.in_ready  (frame.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_left  (result.mix_out_left),
	.out_right (result.mix_out_right),
	.out_end   (result.block_end_out)
);
